@@ rtl/bxpc3_pkg.sv @@
// Shared constants, types and address helpers of the binarized 3x3 convolution block.
package bxpc3_pkg;

  localparam int WORD_BITS_DEF  = 64;
  localparam int MAX_WORDS_DEF  = 8;
  localparam int MAX_OUT_CH_DEF = 64;
  localparam int MAX_DIM_DEF    = 32;

  localparam int TAPS      = 9;
  localparam int SUM_W     = 14;
  localparam int SUM_HI    = 8191;
  localparam int SUM_LO    = -8192;
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int BITS_W    = 64;

  typedef enum logic [1:0] {
    FUNC_WEIGHT  = 2'd0,
    FUNC_ACT     = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_ROWS  = 3'd0,
    CFG_IMG_COLS  = 3'd1,
    CFG_WORDS     = 3'd2,
    CFG_STRIDE    = 3'd3,
    CFG_BORDER    = 3'd4,
    CFG_PAD_MODE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [5:0] img_rows;
    logic [5:0] img_cols;
    logic [3:0] words_per_pixel;
    logic [2:0] stride;
    logic       border;
    logic       pad_mode;
  } cfg_t;

  typedef struct packed {
    logic [5:0] chan;
    logic [4:0] row;
    logic [4:0] col;
  } job_t;

  function automatic int w_addr(int ch, int tap, int wi, int max_words);
    return (ch * TAPS + tap) * max_words + wi;
  endfunction

  function automatic int a_addr(int r, int c, int wi, int max_dim, int max_words);
    return (r * max_dim + c) * max_words + wi;
  endfunction

endpackage

@@ rtl/bxpc3_mem.sv @@
// Single-port-write, registered-read word memory.
module bxpc3_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bxpc3_xnor_pop.sv @@
// Shared xnor-popcount unit: one word pair per cycle, registered signed score.
module bxpc3_xnor_pop #(
  parameter int WORD_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  op_valid,
  input  logic [WORD_BITS-1:0]                  op_w,
  input  logic [WORD_BITS-1:0]                  op_a,
  output logic                                  sc_valid,
  output logic signed [$clog2(WORD_BITS+1)+1:0] sc_score
);

  localparam int NB   = (WORD_BITS + 7) / 8;
  localparam int PW   = $clog2(WORD_BITS + 1);
  localparam int SC_W = PW + 2;

  logic [WORD_BITS-1:0] xn;
  logic [NB*8-1:0]      xb;
  logic [3:0]           byte_cnt [NB];
  logic [PW-1:0]        pop;
  logic signed [SC_W-1:0] score_nxt;
  logic                 sc_valid_r;
  logic signed [SC_W-1:0] sc_score_r;

  assign xn = ~(op_w ^ op_a);
  assign xb = (NB*8)'(xn);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(xb[b*8+i]);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int b = 0; b < NB; b++) begin
      pop = pop + PW'(byte_cnt[b]);
    end
  end

  assign score_nxt = $signed({1'b0, pop, 1'b0}) - $signed(SC_W'(WORD_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else begin
      sc_valid_r <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      sc_score_r <= score_nxt;
    end
  end

  assign sc_valid = sc_valid_r;
  assign sc_score = sc_score_r;

endmodule

@@ rtl/bxpc3_seq.sv @@
// Compute sequencer: tap and word walk, read addressing, accumulation and result register.
module bxpc3_seq #(
  parameter int WORD_BITS  = 64,
  parameter int MAX_WORDS  = 8,
  parameter int MAX_OUT_CH = 64,
  parameter int MAX_DIM    = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  bxpc3_pkg::cfg_t                                   cfg,
  input  logic                                              start,
  input  bxpc3_pkg::job_t                                   job,
  output logic                                              idle,
  output logic                                              rd_re,
  output logic [$clog2(MAX_OUT_CH*bxpc3_pkg::TAPS*MAX_WORDS)-1:0] w_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM*MAX_WORDS)-1:0]     a_raddr,
  input  logic [WORD_BITS-1:0]                              w_rdata,
  input  logic [WORD_BITS-1:0]                              a_rdata,
  output logic                                              op_valid,
  output logic [WORD_BITS-1:0]                              op_w,
  output logic [WORD_BITS-1:0]                              op_a,
  input  logic                                              sc_valid,
  input  logic signed [$clog2(WORD_BITS+1)+1:0]             sc_score,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic signed [bxpc3_pkg::SUM_W-1:0]                out_sum,
  output logic [5:0]                                        out_res_chan,
  output logic [4:0]                                        out_res_row,
  output logic [4:0]                                        out_res_col,
  output logic                                              out_range_error
);

  import bxpc3_pkg::*;

  localparam int WA_W  = $clog2(MAX_OUT_CH * TAPS * MAX_WORDS);
  localparam int AA_W  = $clog2(MAX_DIM * MAX_DIM * MAX_WORDS);
  localparam int ACC_MIN_W = $clog2(TAPS * MAX_WORDS * WORD_BITS + 1) + 1;
  localparam int ACC_W = (ACC_MIN_W > SUM_W + 1) ? ACC_MIN_W : SUM_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SUM_HI);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SUM_LO);

  state_t state_r, state_nxt;

  logic [5:0]         ch_r, ch_nxt;
  logic [4:0]         row_r, row_nxt;
  logic [4:0]         col_r, col_nxt;
  logic [COORD_W-1:0] cr_r, cr_nxt;
  logic [COORD_W-1:0] cc_r, cc_nxt;
  logic               use_w_r, use_w_nxt;
  logic               rerr_r, rerr_nxt;
  logic [3:0]         t_r, t_nxt;
  logic [1:0]         kr_r, kr_nxt;
  logic [1:0]         kc_r, kc_nxt;
  logic [3:0]         w_r, w_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic s1_v_r, s1_usew_r, s1_in_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                    out_load;
  logic [5:0]              res_chan_r;
  logic [4:0]              res_row_r;
  logic [4:0]              res_col_r;
  logic                    res_err_r;

  logic [5:0]         rows_eff, cols_eff;
  logic [3:0]         nw_eff;
  logic [2:0]         st_eff;
  logic [COORD_W-1:0] r_tap, c_tap;
  logic               tap_in, tap_en, issue;
  logic               last_w, last_t;
  logic signed [SUM_W-1:0] sat_sum;

  assign rows_eff = (int'(cfg.img_rows) > MAX_DIM) ? 6'(MAX_DIM) : cfg.img_rows;
  assign cols_eff = (int'(cfg.img_cols) > MAX_DIM) ? 6'(MAX_DIM) : cfg.img_cols;
  assign nw_eff   = (int'(cfg.words_per_pixel) > MAX_WORDS) ? 4'(MAX_WORDS)
                                                              : cfg.words_per_pixel;
  assign st_eff   = (cfg.stride == 3'd0) ? 3'd1 : cfg.stride;

  // MSB set means the tap lies above or left of the image
  assign r_tap  = cfg.border ? (cr_r + COORD_W'(kr_r) - COORD_W'(1)) : cr_r;
  assign c_tap  = cfg.border ? (cc_r + COORD_W'(kc_r) - COORD_W'(1)) : cc_r;
  assign tap_in = !r_tap[COORD_W-1] && (r_tap < COORD_W'(rows_eff)) &&
                  !c_tap[COORD_W-1] && (c_tap < COORD_W'(cols_eff));
  assign tap_en = tap_in || !cfg.pad_mode;
  assign issue  = (state_r == ST_RUN) && tap_en;

  assign rd_re   = issue;
  assign w_raddr = use_w_r ? WA_W'(w_addr(int'(ch_r), int'(t_r), int'(w_r), MAX_WORDS)) : '0;
  assign a_raddr = tap_in ? AA_W'(a_addr(int'(r_tap), int'(c_tap), int'(w_r),
                                         MAX_DIM, MAX_WORDS)) : '0;

  assign op_valid = s1_v_r;
  assign op_w     = s1_usew_r ? w_rdata : '0;
  assign op_a     = s1_in_r ? a_rdata : '0;

  assign last_w = (w_r == nw_eff - 4'd1);
  assign last_t = (t_r == 4'(TAPS - 1));

  assign sat_sum = (acc_r > ACC_HI) ? SUM_W'(SUM_HI) :
                   (acc_r < ACC_LO) ? SUM_W'(SUM_LO) : acc_r[SUM_W-1:0];

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cr_nxt    = cr_r;
    cc_nxt    = cc_r;
    use_w_nxt = use_w_r;
    rerr_nxt  = rerr_r;
    t_nxt     = t_r;
    kr_nxt    = kr_r;
    kc_nxt    = kc_r;
    w_nxt     = w_r;
    acc_nxt   = acc_r;
    if (sc_valid) begin
      acc_nxt = acc_r + ACC_W'(sc_score);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ch_nxt    = job.chan;
          row_nxt   = job.row;
          col_nxt   = job.col;
          cr_nxt    = COORD_W'(job.row) * COORD_W'(st_eff);
          cc_nxt    = COORD_W'(job.col) * COORD_W'(st_eff);
          use_w_nxt = int'(job.chan) < MAX_OUT_CH;
          rerr_nxt  = 1'b0;
          t_nxt     = '0;
          kr_nxt    = '0;
          kc_nxt    = '0;
          w_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if ((cr_r >= COORD_W'(rows_eff)) || (cc_r >= COORD_W'(cols_eff))) begin
          rerr_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (nw_eff == 4'd0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_w) begin
          w_nxt = '0;
          t_nxt = t_r + 4'd1;
          if (kc_r == 2'd2) begin
            kc_nxt = '0;
            kr_nxt = kr_r + 2'd1;
          end else begin
            kc_nxt = kc_r + 2'd1;
          end
          if (last_t) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          w_nxt = w_r + 4'd1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !sc_valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = rerr_r ? '0 : sat_sum;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_v_r      <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    cr_r      <= cr_nxt;
    cc_r      <= cc_nxt;
    use_w_r   <= use_w_nxt;
    rerr_r    <= rerr_nxt;
    t_r       <= t_nxt;
    kr_r      <= kr_nxt;
    kc_r      <= kc_nxt;
    w_r       <= w_nxt;
    acc_r     <= acc_nxt;
    s1_usew_r <= use_w_r;
    s1_in_r   <= tap_in;
    out_sum_r <= out_sum_nxt;
    if (out_load) begin
      res_chan_r <= ch_r;
      res_row_r  <= row_r;
      res_col_r  <= col_r;
      res_err_r  <= rerr_r;
    end
  end

  assign idle            = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sum         = out_sum_r;
  assign out_res_chan    = res_chan_r;
  assign out_res_row     = res_row_r;
  assign out_res_col     = res_col_r;
  assign out_range_error = res_err_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !idle)
    else $error("compute request did not leave idle");

  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (w_r < nw_eff))
    else $error("word counter beyond words per pixel");

  a_tap_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (t_r == (4'(kr_r) * 4'd3 + 4'(kc_r))))
    else $error("tap index out of step with kernel row and column");

  a_pipe_live: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || sc_valid) |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("score in flight outside a compute");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_err_r) |-> (out_sum_r == '0))
    else $error("range error result with non-zero sum");

endmodule

@@ rtl/binary_xnor_popcount_conv3x3.sv @@
// Top level of the binarized 3x3 xnor-popcount convolution block.
// Weight and activation writes are accepted back to back.
// A compute request walks the 9 taps times the words per pixel (capped at MAX_WORDS)
// through one shared xnor-popcount unit, one word pair per cycle from the two memory read
// ports, and holds in_ready low until its result is loaded into the output register; a
// result that is not yet taken blocks that load and so delays every following request.
// Both stores are undefined until written and get no clearing pass after reset.
module binary_xnor_popcount_conv3x3 #(
  parameter int WORD_BITS  = bxpc3_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS  = bxpc3_pkg::MAX_WORDS_DEF,
  parameter int MAX_OUT_CH = bxpc3_pkg::MAX_OUT_CH_DEF,
  parameter int MAX_DIM    = bxpc3_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bxpc3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bxpc3_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [5:0]                         in_out_chan,
  input  logic [3:0]                         in_tap,
  input  logic [4:0]                         in_row,
  input  logic [4:0]                         in_col,
  input  logic [2:0]                         in_word_index,
  input  logic [bxpc3_pkg::BITS_W-1:0]       in_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bxpc3_pkg::SUM_W-1:0] out_sum,
  output logic [5:0]                         out_res_chan,
  output logic [4:0]                         out_res_row,
  output logic [4:0]                         out_res_col,
  output logic                               out_range_error
);

  import bxpc3_pkg::*;

  localparam int W_DEPTH = MAX_OUT_CH * TAPS * MAX_WORDS;
  localparam int A_DEPTH = MAX_DIM * MAX_DIM * MAX_WORDS;
  localparam int WA_W    = $clog2(W_DEPTH);
  localparam int AA_W    = $clog2(A_DEPTH);
  localparam int SC_W    = $clog2(WORD_BITS + 1) + 2;

  cfg_t cfg_r, cfg_nxt;
  job_t job;

  logic accept, start, idle;
  logic w_we, a_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [AA_W-1:0] a_waddr, a_raddr;
  logic [WORD_BITS-1:0] wdata, w_rdata, a_rdata;
  logic rd_re;
  logic op_valid;
  logic [WORD_BITS-1:0] op_w, op_a;
  logic sc_valid;
  logic signed [SC_W-1:0] sc_score;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMG_ROWS: cfg_nxt.img_rows        = cfg_wdata;
        CFG_IMG_COLS: cfg_nxt.img_cols        = cfg_wdata;
        CFG_WORDS:    cfg_nxt.words_per_pixel = cfg_wdata[3:0];
        CFG_STRIDE:   cfg_nxt.stride          = cfg_wdata[2:0];
        CFG_BORDER:   cfg_nxt.border          = cfg_wdata[0];
        CFG_PAD_MODE: cfg_nxt.pad_mode        = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_rows        <= 6'd32;
      cfg_r.img_cols        <= 6'd32;
      cfg_r.words_per_pixel <= 4'd1;
      cfg_r.stride          <= 3'd1;
      cfg_r.border          <= 1'b1;
      cfg_r.pad_mode        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = idle;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_func == FUNC_COMPUTE);

  // out-of-range writes are dropped
  assign w_we = accept && (in_func == FUNC_WEIGHT) && (int'(in_tap) < TAPS) &&
                (int'(in_word_index) < MAX_WORDS) && (int'(in_out_chan) < MAX_OUT_CH);
  assign a_we = accept && (in_func == FUNC_ACT) && (int'(in_word_index) < MAX_WORDS) &&
                (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  assign w_waddr = w_we ? WA_W'(w_addr(int'(in_out_chan), int'(in_tap),
                                       int'(in_word_index), MAX_WORDS)) : '0;
  assign a_waddr = a_we ? AA_W'(a_addr(int'(in_row), int'(in_col), int'(in_word_index),
                                       MAX_DIM, MAX_WORDS)) : '0;
  assign wdata   = in_bits[WORD_BITS-1:0];

  assign job.chan = in_out_chan;
  assign job.row  = in_row;
  assign job.col  = in_col;

  bxpc3_mem #(
    .WIDTH (WORD_BITS),
    .DEPTH (W_DEPTH)
  ) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (wdata),
    .re    (rd_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  bxpc3_mem #(
    .WIDTH (WORD_BITS),
    .DEPTH (A_DEPTH)
  ) u_amem (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .re    (rd_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bxpc3_xnor_pop #(
    .WORD_BITS (WORD_BITS)
  ) u_xpop (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_w     (op_w),
    .op_a     (op_a),
    .sc_valid (sc_valid),
    .sc_score (sc_score)
  );

  bxpc3_seq #(
    .WORD_BITS  (WORD_BITS),
    .MAX_WORDS  (MAX_WORDS),
    .MAX_OUT_CH (MAX_OUT_CH),
    .MAX_DIM    (MAX_DIM)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .start           (start),
    .job             (job),
    .idle            (idle),
    .rd_re           (rd_re),
    .w_raddr         (w_raddr),
    .a_raddr         (a_raddr),
    .w_rdata         (w_rdata),
    .a_rdata         (a_rdata),
    .op_valid        (op_valid),
    .op_w            (op_w),
    .op_a            (op_a),
    .sc_valid        (sc_valid),
    .sc_score        (sc_score),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum         (out_sum),
    .out_res_chan    (out_res_chan),
    .out_res_row     (out_res_row),
    .out_res_col     (out_res_col),
    .out_range_error (out_range_error)
  );

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the binarized 3x3 xnor-popcount convolution block.
`timescale 1ns / 100ps

module tb_top;
  import bxpc3_pkg::*;

  localparam int WBITS = WORD_BITS_DEF;
  localparam int NWORDS = MAX_WORDS_DEF;
  localparam int NCHAN = MAX_OUT_CH_DEF;
  localparam int DIM = MAX_DIM_DEF;
  localparam int WT_DEPTH = NCHAN * TAPS * NWORDS;
  localparam int ACT_DEPTH = DIM * DIM * NWORDS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [BITS_W-1:0] ALL_ONES = {BITS_W{1'b1}};
  localparam logic [BITS_W-1:0] LOW_BYTE = 64'hff;
  localparam int ITEM_TARGET = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int END_LIMIT = 20000;

  typedef struct {
    logic [1:0]        func;
    logic [5:0]        chan;
    logic [3:0]        tap;
    logic [4:0]        row;
    logic [4:0]        col;
    logic [2:0]        word;
    logic [BITS_W-1:0] bits;
  } req_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [5:0]              chan;
    logic [4:0]              row;
    logic [4:0]              col;
    logic                    rerr;
  } pixel_t;

  typedef struct {
    int rows;
    int cols;
    int nw;
    int st;
    int bd;
    int pm;
  } geom_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_func;
  logic [5:0] in_out_chan;
  logic [3:0] in_tap;
  logic [4:0] in_row;
  logic [4:0] in_col;
  logic [2:0] in_word_index;
  logic [BITS_W-1:0] in_bits;
  logic out_valid;
  logic out_ready;
  logic signed [SUM_W-1:0] out_sum;
  logic [5:0] out_res_chan;
  logic [4:0] out_res_row;
  logic [4:0] out_res_col;
  logic out_range_error;

  binary_xnor_popcount_conv3x3 dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_out_chan(in_out_chan),
    .in_tap(in_tap),
    .in_row(in_row),
    .in_col(in_col),
    .in_word_index(in_word_index),
    .in_bits(in_bits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sum(out_sum),
    .out_res_chan(out_res_chan),
    .out_res_row(out_res_row),
    .out_res_col(out_res_col),
    .out_range_error(out_range_error)
  );

  logic [BITS_W-1:0] wt_mem [WT_DEPTH];
  bit wt_ok [WT_DEPTH];
  logic [BITS_W-1:0] act_mem [ACT_DEPTH];
  bit act_ok [ACT_DEPTH];
  cfg_t cfg_cur;
  pixel_t pixel_q [$];
  int errors;
  int live_items;
  int burst_left;
  bit hold_req;

  function automatic int wt_slot(int ch, int t, int w);
    return (ch * TAPS + t) * NWORDS + w;
  endfunction

  function automatic int act_slot(int r, int c, int w);
    return (r * DIM + c) * NWORDS + w;
  endfunction

  function automatic cfg_t mk_setting(int r, int c, int nw, int st, int bd, int pm);
    cfg_t s;
    s.img_rows = 6'(r);
    s.img_cols = 6'(c);
    s.words_per_pixel = 4'(nw);
    s.stride = 3'(st);
    s.border = 1'(bd);
    s.pad_mode = 1'(pm);
    return s;
  endfunction

  function automatic geom_t geometry();
    geom_t g;
    g.rows = (int'(cfg_cur.img_rows) > DIM) ? DIM : int'(cfg_cur.img_rows);
    g.cols = (int'(cfg_cur.img_cols) > DIM) ? DIM : int'(cfg_cur.img_cols);
    g.nw = (int'(cfg_cur.words_per_pixel) > NWORDS) ? NWORDS
                                                      : int'(cfg_cur.words_per_pixel);
    g.st = (cfg_cur.stride == 3'd0) ? 1 : int'(cfg_cur.stride);
    g.bd = int'(cfg_cur.border);
    g.pm = int'(cfg_cur.pad_mode);
    return g;
  endfunction

  function automatic pixel_t predict_pixel(int ch, int row, int col);
    pixel_t p;
    geom_t g;
    int cr, cc, r, c, t, w, acc;
    bit tap_in;
    logic [BITS_W-1:0] av;
    g = geometry();
    p.chan = 6'(ch);
    p.row = 5'(row);
    p.col = 5'(col);
    p.rerr = 1'b0;
    p.sum = '0;
    cr = row * g.st;
    cc = col * g.st;
    if (cr >= g.rows || cc >= g.cols) begin
      p.rerr = 1'b1;
      return p;
    end
    acc = 0;
    for (t = 0; t < TAPS; t++) begin
      r = cr + (t / 3 - 1) * g.bd;
      c = cc + (t % 3 - 1) * g.bd;
      tap_in = r >= 0 && r < g.rows && c >= 0 && c < g.cols;
      if (tap_in || g.pm == 0) begin
        for (w = 0; w < g.nw; w++) begin
          if (tap_in) av = act_mem[act_slot(r, c, w)];
          else av = '0;
          acc += 2 * $countones(~(wt_mem[wt_slot(ch, t, w)] ^ av)) - WBITS;
        end
      end
    end
    if (acc > SUM_HI) acc = SUM_HI;
    if (acc < SUM_LO) acc = SUM_LO;
    p.sum = acc[SUM_W-1:0];
    return p;
  endfunction

  // Store model update on every accepted request
  function automatic void absorb_request(req_t q);
    live_items++;
    case (q.func)
      FUNC_WEIGHT: begin
        if (int'(q.tap) < TAPS) begin
          wt_mem[wt_slot(int'(q.chan), int'(q.tap), int'(q.word))] = q.bits;
          wt_ok[wt_slot(int'(q.chan), int'(q.tap), int'(q.word))] = 1'b1;
        end
      end
      FUNC_ACT: begin
        act_mem[act_slot(int'(q.row), int'(q.col), int'(q.word))] = q.bits;
        act_ok[act_slot(int'(q.row), int'(q.col), int'(q.word))] = 1'b1;
      end
      FUNC_COMPUTE: begin
        pixel_q.push_back(predict_pixel(int'(q.chan), int'(q.row), int'(q.col)));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] rand_word();
    logic [BITS_W-1:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return ALL_ONES;
      1: return '0;
      2: return a & b;
      3: return a | b;
      4: return LOW_BYTE;
      default: return a;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t q;
    q.func = FUNC_COMPUTE;
    q.chan = 6'($urandom);
    q.tap = 4'($urandom);
    q.row = 5'($urandom);
    q.col = 5'($urandom);
    q.word = 3'($urandom);
    q.bits = {$urandom, $urandom};
    return q;
  endfunction

  function automatic req_t weight_req(int ch, int t, int w, logic [BITS_W-1:0] bits);
    req_t q;
    q = random_req();
    q.func = FUNC_WEIGHT;
    q.chan = 6'(ch);
    q.tap = 4'(t);
    q.word = 3'(w);
    q.bits = bits;
    return q;
  endfunction

  function automatic req_t act_req(int r, int c, int w, logic [BITS_W-1:0] bits);
    req_t q;
    q = random_req();
    q.func = FUNC_ACT;
    q.row = 5'(r);
    q.col = 5'(c);
    q.word = 3'(w);
    q.bits = bits;
    return q;
  endfunction

  function automatic req_t compute_req(int ch, int r, int c);
    req_t q;
    q = random_req();
    q.chan = 6'(ch);
    q.row = 5'(r);
    q.col = 5'(c);
    return q;
  endfunction

  function automatic cfg_t rand_setting();
    cfg_t s;
    int dim_hi;
    s.words_per_pixel = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(3, 8)
                                                        : $urandom_range(1, 2));
    if (int'(s.words_per_pixel) > 2) dim_hi = 6;
    else dim_hi = ($urandom_range(0, 2) == 0) ? DIM : 10;
    s.img_rows = 6'($urandom_range(1, dim_hi));
    s.img_cols = 6'($urandom_range(1, dim_hi));
    s.stride = 3'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
    s.border = 1'($urandom_range(0, 1));
    s.pad_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 11))
      0: s.img_rows = 6'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
      1: s.img_cols = 6'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
      2: s.words_per_pixel = 4'($urandom_range(0, 1) ? 0 : $urandom_range(9, 15));
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_request(req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= q.func;
    in_out_chan <= q.chan;
    in_tap <= q.tap;
    in_row <= q.row;
    in_col <= q.col;
    in_word_index <= q.word;
    in_bits <= q.bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_request(q);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Upper data bits above a register's width carry junk
  task automatic apply_setting(cfg_t s);
    cfg_idx_t order [6];
    logic [CFG_W-1:0] vals [6];
    logic [CFG_W-1:0] junk;
    int i;
    junk = 6'($urandom);
    order[0] = CFG_IMG_ROWS;
    order[1] = CFG_IMG_COLS;
    order[2] = CFG_WORDS;
    order[3] = CFG_STRIDE;
    order[4] = CFG_BORDER;
    order[5] = CFG_PAD_MODE;
    vals[0] = s.img_rows;
    vals[1] = s.img_cols;
    vals[2] = {junk[5:4], s.words_per_pixel};
    vals[3] = {junk[5:3], s.stride};
    vals[4] = {junk[5:1], s.border};
    vals[5] = {junk[4:0], s.pad_mode};
    for (i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_cur = s;
  endtask

  // Writes whatever the compute would read that has never been written, then computes
  task automatic prime_and_compute(int ch, int row, int col);
    geom_t g;
    int cr, cc, r, c, t, w;
    bit tap_in;
    g = geometry();
    cr = row * g.st;
    cc = col * g.st;
    if (cr < g.rows && cc < g.cols) begin
      for (t = 0; t < TAPS; t++) begin
        r = cr + (t / 3 - 1) * g.bd;
        c = cc + (t % 3 - 1) * g.bd;
        tap_in = r >= 0 && r < g.rows && c >= 0 && c < g.cols;
        for (w = 0; w < g.nw; w++) begin
          if (!wt_ok[wt_slot(ch, t, w)]) send_request(weight_req(ch, t, w, rand_word()));
          if (tap_in && !act_ok[act_slot(r, c, w)])
            send_request(act_req(r, c, w, rand_word()));
        end
      end
    end
    send_request(compute_req(ch, row, col));
  endtask

  task automatic compute_somewhere(int chan_hi);
    geom_t g;
    int row, col;
    g = geometry();
    if ($urandom_range(0, 6) == 0 || g.rows == 0 || g.cols == 0) begin
      row = $urandom_range(0, 31);
      col = $urandom_range(0, 31);
    end else begin
      row = $urandom_range(0, (g.rows - 1) / g.st);
      col = $urandom_range(0, (g.cols - 1) / g.st);
    end
    prime_and_compute($urandom_range(0, chan_hi), row, col);
  endtask

  task automatic test_basic_ops();
    req_t q;
    int t;
    for (t = 0; t < TAPS; t++) send_request(weight_req(0, t, 0, (t == 4) ? '0 : ALL_ONES));
    send_request(act_req(0, 0, 0, ALL_ONES));
    send_request(act_req(0, 1, 0, '0));
    send_request(act_req(1, 0, 0, LOW_BYTE));
    send_request(act_req(1, 1, 0, rand_word()));
    q = random_req();
    q.func = FUNC_UNUSED;
    send_request(q);
    send_request(weight_req(NCHAN - 1, 15, NWORDS - 1, rand_word()));
    send_request(compute_req(0, 0, 0));
    send_request(act_req(DIM - 1, DIM - 1, NWORDS - 1, ALL_ONES));
    prime_and_compute(0, DIM - 1, DIM - 1);
  endtask

  task automatic test_config_corners();
    cfg_t corners [8];
    int k;
    corners[0] = mk_setting(1, 1, 1, 1, 1, 1);
    corners[1] = mk_setting(0, 63, 1, 1, 1, 0);
    corners[2] = mk_setting(63, 5, 0, 0, 0, 0);
    corners[3] = mk_setting(3, 32, 8, 4, 1, 0);
    corners[4] = mk_setting(4, 4, 15, 7, 0, 1);
    corners[5] = mk_setting(32, 32, 2, 2, 1, 1);
    corners[6] = mk_setting(32, 1, 1, 1, 1, 0);
    corners[7] = mk_setting(5, 0, 3, 1, 0, 1);
    foreach (corners[i]) begin
      wait_idle();
      apply_setting(corners[i]);
      for (k = 0; k < 3; k++) compute_somewhere(NCHAN - 1);
    end
  endtask

  // Result side held off long enough for the block to back up into its input
  task automatic test_result_backpressure();
    int k;
    wait_idle();
    apply_setting(mk_setting(8, 8, 1, 1, 1, 0));
    for (k = 0; k < 4; k++) compute_somewhere(3);
    hold_req = 1'b1;
    for (k = 0; k < 16; k++) compute_somewhere(3);
    wait_idle();
    for (k = 0; k < 6; k++) compute_somewhere(3);
  endtask

  task automatic test_random_traffic();
    geom_t g;
    req_t q;
    int n;
    while (live_items < ITEM_TARGET) begin
      wait_idle();
      apply_setting(rand_setting());
      g = geometry();
      n = 0;
      while (n < 150 && live_items < ITEM_TARGET) begin
        case ($urandom_range(0, 19)) inside
          [0:10]: compute_somewhere(NCHAN - 1);
          [11:12]: begin
            send_request(act_req($urandom_range(0, (g.rows > 0) ? g.rows - 1 : 31),
                                 $urandom_range(0, (g.cols > 0) ? g.cols - 1 : 31),
                                 $urandom_range(0, 7), rand_word()));
          end
          [13:14]: begin
            send_request(weight_req($urandom_range(0, NCHAN - 1), $urandom_range(0, TAPS - 1),
                                    $urandom_range(0, (g.nw > 0) ? g.nw - 1 : 0), rand_word()));
          end
          [15:17]: begin
            q = random_req();
            q.func = $urandom_range(0, 1) ? FUNC_WEIGHT : FUNC_ACT;
            send_request(q);
          end
          default: begin
            q = random_req();
            if ($urandom_range(0, 1)) begin
              q.func = FUNC_UNUSED;
            end else begin
              q.func = FUNC_WEIGHT;
              q.tap = 4'($urandom_range(TAPS, 15));
            end
            send_request(q);
          end
        endcase
        n++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : receiver
    int mode, mode_left, hold_left, beat;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (beat % 4) != 0;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: sum %0d chan %0d row %0d col %0d err %0b",
                   out_sum, out_res_chan, out_res_row, out_res_col, out_range_error);
      end else begin
        want = pixel_q.pop_front();
        if (out_sum !== want.sum || out_res_chan !== want.chan || out_res_row !== want.row ||
            out_res_col !== want.col || out_range_error !== want.rerr) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want sum %0d chan %0d row %0d col %0d err %0b, %s %0d %0d %0d %0d %0b",
                     want.sum, want.chan, want.row, want.col, want.rerr, "got",
                     out_sum, out_res_chan, out_res_row, out_res_col, out_range_error);
        end
      end
    end
  end

  initial begin : main_sequence
    int guard;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMG_ROWS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = FUNC_WEIGHT;
    in_out_chan = '0;
    in_tap = '0;
    in_row = '0;
    in_col = '0;
    in_word_index = '0;
    in_bits = '0;
    errors = 0;
    live_items = 0;
    burst_left = 0;
    hold_req = 1'b0;
    cfg_cur = mk_setting(32, 32, 1, 1, 1, 0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_config_corners();
    test_result_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pixel_q.size() != 0 && guard < END_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pixel_q.size() != 0) begin
      $display("%0d results never arrived", pixel_q.size());
      errors += pixel_q.size();
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
